@@ hw/rtl/tlgp_pkg.sv @@
// Types, constants and helpers for the text layout glyph placer.
// Used by text_layout_glyph_placer; depends on nothing.
package tlgp_pkg;

  localparam int MAP_ENTRIES = 256;
  localparam int MAP_AW      = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAP_ENTRIES + 1);
  localparam int ENTRY_W     = 24;

  // Request opcodes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_PLACE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_CELL_W   = 3'd0;
  localparam logic [2:0] REG_CELL_H   = 3'd1;
  localparam logic [2:0] REG_LEFT     = 3'd2;
  localparam logic [2:0] REG_TOP      = 3'd3;
  localparam logic [2:0] REG_RIGHT    = 3'd4;
  localparam logic [2:0] REG_MAP_LEN  = 3'd5;

  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam logic [7:0]  CH_NEWLINE  = 8'h0a;
  localparam logic [15:0] ROW_MASK    = 16'hff00;
  localparam logic [15:0] ROW_STEP    = 16'h0100;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRE  = 6'b000010,
    S_SCAN = 6'b000100,
    S_POST = 6'b001000,
    S_BOX  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/tlgp_map_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Holds the char map; no dependencies.
module tlgp_map_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/text_layout_glyph_placer.sv @@
// Text layout glyph placer: cursor/pen tracking, char map lookup, bounding box.
// Depends on tlgp_pkg and tlgp_map_ram.
// Load and unused requests go straight to the result; start and newline requests pass
// through S_PRE first; other place requests scan n = min(map_length, 256) map entries
// in one pass of the map RAM read port, one entry per cycle, skipped for a space or n = 0.
// One request at a time; a new request is taken the cycle after the result leaves.
// Reset (synchronous, rst_n low) clears pen, cursor, box and restores register
// defaults; the char map itself is not cleared.
module text_layout_glyph_placer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_entry_index,
  input  logic [7:0]  in_glyph_width,
  input  logic [7:0]  in_glyph_height,
  input  logic [15:0] in_start_cursor,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_glyph_found,
  output logic [7:0]  out_glyph_index,
  output logic signed [15:0] out_place_x,
  output logic signed [15:0] out_place_y,
  output logic [7:0]  out_place_w,
  output logic [7:0]  out_place_h,
  output logic [15:0] out_cursor_out,
  output logic signed [15:0] out_box_x,
  output logic signed [15:0] out_box_y,
  output logic [15:0] out_box_w,
  output logic [15:0] out_box_h,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  tlgp_pkg::state_t state_r;

  logic [7:0]  cell_w_r, cell_h_r;
  logic [15:0] left_r, top_r, right_r;
  logic [8:0]  map_len_r;

  logic [1:0]  op_r;
  logic [7:0]  ch_r;
  logic [15:0] sc_r;

  logic [15:0] pen_x_r, pen_y_r, cursor_r;
  logic [15:0] bb_x_r, bb_y_r, bb_w_r, bb_h_r;

  logic [tlgp_pkg::CNT_W-1:0]  cnt_r;
  logic                        rd_vld_r;
  logic [tlgp_pkg::MAP_AW-1:0] rd_idx_r;
  logic                        ex_vld_r, ci_vld_r;
  logic [tlgp_pkg::MAP_AW-1:0] ex_idx_r, ci_idx_r;
  logic [7:0]                  ex_w_r, ex_h_r, ci_w_r, ci_h_r;

  logic [15:0] nx_r, ny_r;

  logic        found_r;
  logic [7:0]  gidx_r;
  logic [15:0] px_r, py_r;
  logic [7:0]  pw_r, ph_r;

  logic [tlgp_pkg::ENTRY_W-1:0] rdata;
  logic                         map_we;
  logic [tlgp_pkg::CNT_W-1:0]   scan_n;
  logic                         in_fire;

  logic        nl, wrap;
  logic [15:0] pen_x_nxt, pen_y_nxt, cursor_nxt;
  logic [15:0] start_x_nxt, start_y_nxt;
  logic [7:0]  sel_w_nxt, sel_h_nxt;
  logic signed [17:0] ew_nxt, eh_nxt;

  assign in_ready = (state_r == tlgp_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign map_we   = in_fire && (in_op == tlgp_pkg::OP_LOAD) &&
                    ({1'b0, in_entry_index} < 9'(tlgp_pkg::MAP_ENTRIES));

  assign scan_n = (map_len_r > 9'(tlgp_pkg::MAP_ENTRIES)) ?
                  tlgp_pkg::CNT_W'(tlgp_pkg::MAP_ENTRIES) :
                  tlgp_pkg::CNT_W'(map_len_r);

  tlgp_map_ram #(
    .WIDTH(tlgp_pkg::ENTRY_W),
    .DEPTH(tlgp_pkg::MAP_ENTRIES)
  ) u_map_ram (
    .clk  (clk),
    .we   (map_we),
    .waddr(in_entry_index[tlgp_pkg::MAP_AW-1:0]),
    .wdata({in_glyph_height, in_glyph_width, in_char_code}),
    .raddr(cnt_r[tlgp_pkg::MAP_AW-1:0]),
    .rdata(rdata)
  );

  // Line wrap step of a place request and start position of a start request.
  always_comb begin
    nl   = (ch_r == tlgp_pkg::CH_NEWLINE);
    wrap = nl || ($signed(pen_x_r) >= $signed(right_r));
    pen_x_nxt  = wrap ? left_r : pen_x_r;
    pen_y_nxt  = wrap ? (pen_y_r + {8'd0, cell_h_r}) : pen_y_r;
    cursor_nxt = wrap ? ((cursor_r & tlgp_pkg::ROW_MASK) + tlgp_pkg::ROW_STEP) : cursor_r;
    start_x_nxt = 16'({8'd0, sc_r[7:0]} * {8'd0, cell_w_r}) + left_r;
    start_y_nxt = 16'({8'd0, sc_r[15:8]} * {8'd0, cell_h_r}) + top_r;
  end

  // Exact match wins over a case-insensitive one; missing glyphs use the cell.
  always_comb begin
    if (ex_vld_r) begin
      sel_w_nxt = ex_w_r;
      sel_h_nxt = ex_h_r;
    end else if (ci_vld_r) begin
      sel_w_nxt = ci_w_r;
      sel_h_nxt = ci_h_r;
    end else begin
      sel_w_nxt = cell_w_r;
      sel_h_nxt = cell_h_r;
    end
  end

  // Extents of the grown box, measured from the new minimum corner.
  always_comb begin
    ew_nxt = {{2{pen_x_r[15]}}, pen_x_r} + {10'd0, pw_r} - {{2{nx_r[15]}}, nx_r};
    eh_nxt = {{2{pen_y_r[15]}}, pen_y_r} + {10'd0, ph_r} - {{2{ny_r[15]}}, ny_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tlgp_pkg::S_IDLE;
      cell_w_r  <= 8'd8;
      cell_h_r  <= 8'd9;
      left_r    <= 16'd0;
      top_r     <= 16'd0;
      right_r   <= 16'd320;
      map_len_r <= 9'd26;
      pen_x_r   <= '0;
      pen_y_r   <= '0;
      cursor_r  <= '0;
      bb_x_r    <= '0;
      bb_y_r    <= '0;
      bb_w_r    <= '0;
      bb_h_r    <= '0;
      cnt_r     <= '0;
      rd_vld_r  <= 1'b0;
      ex_vld_r  <= 1'b0;
      ci_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tlgp_pkg::REG_CELL_W:  cell_w_r  <= cfg_wdata[7:0];
          tlgp_pkg::REG_CELL_H:  cell_h_r  <= cfg_wdata[7:0];
          tlgp_pkg::REG_LEFT:    left_r    <= cfg_wdata;
          tlgp_pkg::REG_TOP:     top_r     <= cfg_wdata;
          tlgp_pkg::REG_RIGHT:   right_r   <= cfg_wdata;
          tlgp_pkg::REG_MAP_LEN: map_len_r <= cfg_wdata[8:0];
          default: ;
        endcase
      end

      case (state_r)
        tlgp_pkg::S_IDLE: begin
          if (in_fire) begin
            op_r    <= in_op;
            ch_r    <= in_char_code;
            sc_r    <= in_start_cursor;
            found_r <= 1'b0;
            gidx_r  <= 8'd0;
            pw_r    <= 8'd0;
            ph_r    <= 8'd0;
            px_r    <= pen_x_r;
            py_r    <= pen_y_r;
            if (in_op == tlgp_pkg::OP_START || in_op == tlgp_pkg::OP_PLACE) begin
              state_r <= tlgp_pkg::S_PRE;
            end else begin
              state_r <= tlgp_pkg::S_OUT;
            end
          end
        end

        tlgp_pkg::S_PRE: begin
          cnt_r    <= '0;
          rd_vld_r <= 1'b0;
          ex_vld_r <= 1'b0;
          ci_vld_r <= 1'b0;
          if (op_r == tlgp_pkg::OP_START) begin
            cursor_r <= sc_r;
            pen_x_r  <= start_x_nxt;
            pen_y_r  <= start_y_nxt;
            px_r     <= start_x_nxt;
            py_r     <= start_y_nxt;
            bb_x_r   <= '0;
            bb_y_r   <= '0;
            bb_w_r   <= '0;
            bb_h_r   <= '0;
            state_r  <= tlgp_pkg::S_OUT;
          end else begin
            pen_x_r  <= pen_x_nxt;
            pen_y_r  <= pen_y_nxt;
            cursor_r <= cursor_nxt;
            if (nl) begin
              px_r    <= pen_x_nxt;
              py_r    <= pen_y_nxt;
              state_r <= tlgp_pkg::S_OUT;
            end else if (ch_r == tlgp_pkg::CH_SPACE || scan_n == '0) begin
              state_r <= tlgp_pkg::S_POST;
            end else begin
              state_r <= tlgp_pkg::S_SCAN;
            end
          end
        end

        tlgp_pkg::S_SCAN: begin
          // Each address is issued to the RAM and its entry is compared in the cycle after.
          rd_vld_r <= (cnt_r < scan_n);
          rd_idx_r <= cnt_r[tlgp_pkg::MAP_AW-1:0];
          if (cnt_r < scan_n) begin
            cnt_r <= cnt_r + tlgp_pkg::CNT_W'(1);
          end
          if (rd_vld_r) begin
            if (!ex_vld_r && rdata[7:0] == ch_r) begin
              ex_vld_r <= 1'b1;
              ex_idx_r <= rd_idx_r;
              ex_w_r   <= rdata[15:8];
              ex_h_r   <= rdata[23:16];
            end
            if (!ci_vld_r &&
                tlgp_pkg::lower_ascii(rdata[7:0]) == tlgp_pkg::lower_ascii(ch_r)) begin
              ci_vld_r <= 1'b1;
              ci_idx_r <= rd_idx_r;
              ci_w_r   <= rdata[15:8];
              ci_h_r   <= rdata[23:16];
            end
          end
          if (cnt_r >= scan_n && !rd_vld_r) begin
            state_r <= tlgp_pkg::S_POST;
          end
        end

        tlgp_pkg::S_POST: begin
          found_r <= ex_vld_r || ci_vld_r;
          if (ex_vld_r) begin
            gidx_r <= 8'(ex_idx_r);
          end else if (ci_vld_r) begin
            gidx_r <= 8'(ci_idx_r);
          end else begin
            gidx_r <= 8'd0;
          end
          pw_r <= sel_w_nxt;
          ph_r <= sel_h_nxt;
          px_r <= pen_x_r;
          py_r <= pen_y_r;
          nx_r <= ($signed(pen_x_r) < $signed(bb_x_r)) ? pen_x_r : bb_x_r;
          ny_r <= ($signed(pen_y_r) < $signed(bb_y_r)) ? pen_y_r : bb_y_r;
          state_r <= tlgp_pkg::S_BOX;
        end

        tlgp_pkg::S_BOX: begin
          if (bb_w_r == 16'd0) begin
            bb_x_r <= pen_x_r;
            bb_y_r <= pen_y_r;
            bb_w_r <= {8'd0, pw_r};
            bb_h_r <= {8'd0, ph_r};
          end else begin
            bb_x_r <= nx_r;
            bb_y_r <= ny_r;
            if (ew_nxt > $signed({2'b00, bb_w_r})) begin
              bb_w_r <= ew_nxt[15:0];
            end
            if (eh_nxt > $signed({2'b00, bb_h_r})) begin
              bb_h_r <= eh_nxt[15:0];
            end
          end
          pen_x_r  <= pen_x_r + {8'd0, pw_r};
          cursor_r <= cursor_r + 16'd1;
          state_r  <= tlgp_pkg::S_OUT;
        end

        tlgp_pkg::S_OUT: begin
          if (out_ready) begin
            state_r <= tlgp_pkg::S_IDLE;
          end
        end

        default: state_r <= tlgp_pkg::S_IDLE;
      endcase
    end
  end

  assign out_valid       = (state_r == tlgp_pkg::S_OUT);
  assign out_glyph_found = found_r;
  assign out_glyph_index = gidx_r;
  assign out_place_x     = px_r;
  assign out_place_y     = py_r;
  assign out_place_w     = pw_r;
  assign out_place_h     = ph_r;
  assign out_cursor_out  = cursor_r;
  assign out_box_x       = bb_x_r;
  assign out_box_y       = bb_y_r;
  assign out_box_w       = bb_w_r;
  assign out_box_h       = bb_h_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request accepted while a result is pending");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tlgp_pkg::S_SCAN) |-> (cnt_r <= scan_n))
    else $error("map scan ran past the search length");

  a_found_only_place: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_glyph_found) |-> (op_r == tlgp_pkg::OP_PLACE))
    else $error("glyph reported for a request that is not a place");

  a_start_clears_box: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && op_r == tlgp_pkg::OP_START) |-> (bb_w_r == 16'd0 && bb_h_r == 16'd0))
    else $error("start request left a non-empty box");

  a_exact_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tlgp_pkg::S_SCAN && $past(state_r) == tlgp_pkg::S_SCAN &&
     $past(ex_vld_r)) |-> $stable(ex_idx_r))
    else $error("first exact match was overwritten");

endmodule
